// ===== sv/egdbe_pkg.sv =====
`default_nettype none

package egdbe_pkg;

  localparam int KIND_W     = 2;
  localparam int VALUE_BITS = 64;
  localparam int RAW_W      = 7;
  localparam int S_DATA_W   = 72;
  localparam int BYTE_W     = 8;
  localparam int PEND_W     = 7;
  localparam int CNT_W      = 3;

  localparam logic [KIND_W-1:0] KIND_RAW   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GAMMA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELTA = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

  localparam logic [CNT_W-1:0] CNT_FULL = 3'd7;

endpackage

`default_nettype wire

// ===== sv/elias_gamma_delta_bit_encoder_unit.sv =====
// Channel  Direction  Word fields (low bit up)                       Marks
// s_axis   in         tdata: value[63:0], raw_width[70:64], pad[71]  tuser: kind[1:0]
// m_axis   out        tdata: out_byte[7:0]                           tlast: last, tuser: error
//
// One word is taken at a time; each code bit goes into the byte shifter in a cycle of its own.
// Raw words shift out their low raw_width bits from the top down; gamma and delta words first scan the
// value from the top bit down, one bit a cycle, to find its highest set bit, then shift out their code
// bits. Flush and error words go straight to the final step that puts out the held byte.
// Reset is synchronous and clears the held bits and both output slots.
// A stalled m_tready holds the shifter only when a second byte completes before the first left.
`default_nettype none

module elias_gamma_delta_bit_encoder_unit #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // value [63:0], raw_width [70:64], pad [71]
  input  logic [egdbe_pkg::S_DATA_W-1:0] s_tdata,
  // kind [1:0]
  input  logic [egdbe_pkg::KIND_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_byte [7:0]
  output logic [egdbe_pkg::BYTE_W-1:0]   m_tdata,
  output logic                          m_tlast,
  // error [0]
  output logic [0:0]                    m_tuser
);

  import egdbe_pkg::*;

  localparam int IW = $clog2(VALUE_WIDTH + 1);
  localparam int SW = $clog2(VALUE_WIDTH);
  localparam int LW = $clog2(IW + 1);
  localparam int HW = (IW > 1) ? $clog2(IW) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ZERO = 3'd2;
  localparam logic [2:0] S_HDR  = 3'd3;
  localparam logic [2:0] S_BITS = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  function automatic logic [LW-1:0] bit_len(input logic [IW-1:0] n);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < IW; i++) begin
      if (n[i]) begin
        r = LW'(i + 1);
      end
    end
    return r;
  endfunction

  logic [2:0]             state;
  logic [KIND_W-1:0]      kind_r;
  logic [VALUE_WIDTH-1:0] src;
  logic [IW-1:0]          idx;
  logic [IW-1:0]          blen;
  logic [LW-1:0]          hlen;
  logic [PEND_W-1:0]      pend_bits;
  logic [CNT_W-1:0]       pend_cnt;
  logic                   hold_valid;
  logic [BYTE_W-1:0]      hold_byte;
  logic                   hold_err;
  logic                   out_valid;
  logic [BYTE_W-1:0]      out_byte;
  logic                   out_last;
  logic                   out_err;

  logic [VALUE_BITS-1:0]  in_value;
  logic [RAW_W-1:0]       in_rw;
  logic [VALUE_WIDTH-1:0] in_src;
  logic [IW-1:0]          rw_sat;
  logic [BYTE_W-1:0]      flush_byte;
  logic [SW-1:0]          src_sel;
  logic [HW-1:0]          blen_sel;
  logic [LW-1:0]          hl;
  logic                   out_free;
  logic                   emitting;
  logic                   byte_done;
  logic                   step;
  logic                   idx_last;
  logic                   bit_now;
  logic                   out_load;

  assign in_value   = s_tdata[VALUE_BITS-1:0];
  assign in_rw      = s_tdata[VALUE_BITS +: RAW_W];
  assign in_src     = in_value[VALUE_WIDTH-1:0];
  assign rw_sat     = (in_rw > RAW_W'(VALUE_WIDTH)) ? IW'(VALUE_WIDTH) : IW'(in_rw);
  assign flush_byte = BYTE_W'({pend_bits, 1'b0} << (CNT_FULL - pend_cnt));
  assign src_sel    = SW'(idx - IW'(1));
  assign blen_sel   = HW'(idx - IW'(1));
  assign hl         = bit_len(idx);
  assign idx_last   = (idx == IW'(1));
  assign out_free   = !out_valid || m_tready;
  assign emitting   = (state == S_ZERO) || (state == S_HDR) || (state == S_BITS);
  assign byte_done  = (pend_cnt == CNT_FULL);
  assign step       = emitting && (!byte_done || !hold_valid || out_free);
  assign out_load   = ((state == S_FIN) && hold_valid && out_free)
                      || (step && byte_done && hold_valid);

  always_comb begin
    unique case (state)
      S_HDR:   bit_now = blen[blen_sel];
      S_BITS:  bit_now = src[src_sel];
      default: bit_now = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_bits  <= '0;
      pend_cnt   <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && m_tready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind_r <= s_tuser;
            src    <= in_src;
            unique case (s_tuser)
              KIND_RAW: begin
                idx   <= rw_sat;
                state <= (rw_sat == '0) ? S_FIN : S_BITS;
              end
              KIND_GAMMA, KIND_DELTA: begin
                if (in_src == '0) begin
                  hold_valid <= 1'b1;
                  hold_byte  <= '0;
                  hold_err   <= 1'b1;
                  state      <= S_FIN;
                end else begin
                  idx   <= IW'(VALUE_WIDTH);
                  state <= S_SCAN;
                end
              end
              KIND_FLUSH: begin
                if (pend_cnt != '0) begin
                  hold_valid <= 1'b1;
                  hold_byte  <= flush_byte;
                  hold_err   <= 1'b0;
                  pend_bits  <= '0;
                  pend_cnt   <= '0;
                end
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (src[src_sel]) begin
            blen <= idx;
            hlen <= hl;
            if (kind_r == KIND_GAMMA) begin
              if (idx_last) begin
                state <= S_BITS;
              end else begin
                idx   <= idx - IW'(1);
                state <= S_ZERO;
              end
            end else begin
              if (hl == LW'(1)) begin
                idx   <= IW'(hl);
                state <= S_HDR;
              end else begin
                idx   <= IW'(hl) - IW'(1);
                state <= S_ZERO;
              end
            end
          end else begin
            idx <= idx - IW'(1);
          end
        end
        S_ZERO: begin
          if (step) begin
            if (idx_last) begin
              if (kind_r == KIND_GAMMA) begin
                idx   <= blen;
                state <= S_BITS;
              end else begin
                idx   <= IW'(hlen);
                state <= S_HDR;
              end
            end else begin
              idx <= idx - IW'(1);
            end
          end
        end
        S_HDR: begin
          if (step) begin
            if (idx_last) begin
              if (blen == IW'(1)) begin
                state <= S_FIN;
              end else begin
                idx   <= blen - IW'(1);
                state <= S_BITS;
              end
            end else begin
              idx <= idx - IW'(1);
            end
          end
        end
        S_BITS: begin
          if (step) begin
            if (idx_last) begin
              state <= S_FIN;
            end else begin
              idx <= idx - IW'(1);
            end
          end
        end
        S_FIN: begin
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_byte   <= hold_byte;
            out_last   <= 1'b1;
            out_err    <= hold_err;
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (step) begin
        if (byte_done) begin
          if (hold_valid) begin
            out_valid <= 1'b1;
            out_byte  <= hold_byte;
            out_last  <= 1'b0;
            out_err   <= hold_err;
          end
          hold_valid <= 1'b1;
          hold_byte  <= {pend_bits, bit_now};
          hold_err   <= 1'b0;
          pend_bits  <= '0;
          pend_cnt   <= '0;
        end else begin
          pend_bits <= {pend_bits[PEND_W-2:0], bit_now};
          pend_cnt  <= pend_cnt + CNT_W'(1);
        end
      end
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;
  assign m_tuser  = out_err;

endmodule

`default_nettype wire

// ===== sv/egdbe_checker.sv =====
`default_nettype none

module egdbe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [egdbe_pkg::S_DATA_W-1:0] s_tdata,
  input logic [egdbe_pkg::KIND_W-1:0]   s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [egdbe_pkg::BYTE_W-1:0]   m_tdata,
  input logic                          m_tlast,
  input logic [0:0]                    m_tuser
);

  import egdbe_pkg::*;

  // A word waiting on the output keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output word changed while stalled");

  // An error word is a zero byte and closes its input word.
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && m_tlast)
    else $error("error word is not a final zero byte");

  // The encoder works on one input word at a time.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on two cycles in a row");

  // Reset leaves no output word pending.
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // With the output free, a zero gamma or delta value gives an error word through the hold and output slots.
  a_zero_err: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_GAMMA || s_tuser == KIND_DELTA)
      && s_tdata[VALUE_BITS-1:0] == '0 && (!m_tvalid || m_tready)
      |=> ##1 m_tvalid && m_tuser[0])
    else $error("zero value did not give an error word");

endmodule

bind elias_gamma_delta_bit_encoder_unit egdbe_checker u_egdbe_checker (.*);

`default_nettype wire
